// ----- sv/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STP_ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("stp assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define STP_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("stp assertion failed");

`endif

// ----- sv/stp_pkg.sv -----
// ----------------------------------------------------------------------------
// stp_pkg
// Widths, register codes, reset values and control types of the stick to
// pointer delta unit.
// ----------------------------------------------------------------------------
package stp_pkg;

	localparam int STICK_W    = 8;
	localparam int DT_W       = 16;
	localparam int DZ_W       = 7;
	localparam int SENS_W     = 24;
	localparam int RATIO_W    = 17;
	localparam int FRAC_W     = 16;
	localparam int REM_W      = FRAC_W + 1;
	localparam int DELTA_W    = 16;
	localparam int INCR_SHIFT = 24;
	localparam int P1_W       = SENS_W + DT_W;
	localparam int P2_W       = P1_W + RATIO_W;
	localparam int INCR_W     = P2_W - INCR_SHIFT;
	localparam int SUM_W      = INCR_W + 2;
	localparam int WHOLE_W    = SUM_W - FRAC_W;

	localparam int IN_DATA_W  = 2 * STICK_W + DT_W;
	localparam int OUT_DATA_W = 2 * DELTA_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = SENS_W;

	localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SENS_X    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SENS_Y    = 2'd2;

	localparam logic [DZ_W-1:0]   DZ_RESET   = 7'd8;
	localparam logic [SENS_W-1:0] SENS_RESET = 24'd256000;

	localparam logic [RATIO_W-1:0] RATIO_MAX = {RATIO_W{1'b1}};
	localparam logic [DELTA_W-1:0] DELTA_MAX = {1'b0, {(DELTA_W-1){1'b1}}};
	localparam logic [DELTA_W-1:0] DELTA_MIN = {1'b1, {(DELTA_W-1){1'b0}}};

	typedef logic [DELTA_W-1:0] delta_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic mul1_step;
		logic mul2_load;
		logic mul2_step;
		logic finish;
	} stp_ctrl_t;

endpackage

// ----- sv/stick_to_pointer_delta_unit.sv -----
// ----------------------------------------------------------------------------
// stick_to_pointer_delta_unit
// Stick positions and frame time in, whole pointer movement per axis out.
// ----------------------------------------------------------------------------
// A request runs through the divide, multiplier load, multiply and finish
// states before its result is valid. A new request is taken only when idle,
// after the 17-step divide and 17-step ratio multiply (one bit per cycle each).
// The output register holds a result while the next request is taken.
// Reset clears remainders and the output valid flag, and loads register defaults.
module stick_to_pointer_delta_unit #(
	parameter int HALF_RANGE = 128
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// [7:0] stick_x, [15:8] stick_y, [31:16] frame_time
	input  logic [stp_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// [15:0] delta_x, [31:16] delta_y
	output logic [stp_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [stp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [stp_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int CNT_W = $clog2(stp_pkg::RATIO_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(stp_pkg::RATIO_W - 1);
	localparam logic [CNT_W-1:0] CNT_DT   = CNT_W'(stp_pkg::DT_W);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIV  = 3'd1;
	localparam logic [2:0] S_MLD  = 3'd2;
	localparam logic [2:0] S_MUL  = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	logic [2:0]                     state_q;
	logic [CNT_W-1:0]               cnt_q;
	logic [stp_pkg::DZ_W-1:0]       dead_zone_q;
	logic [stp_pkg::SENS_W-1:0]     sens_x_q;
	logic [stp_pkg::SENS_W-1:0]     sens_y_q;
	logic                           out_valid_q;
	logic [stp_pkg::OUT_DATA_W-1:0] out_data_q;
	logic                           s_accept;
	logic                           m_accept;
	logic                           out_free;
	stp_pkg::stp_ctrl_t             ctrl;
	stp_pkg::delta_t                delta_x;
	stp_pkg::delta_t                delta_y;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = state_q == S_IDLE;
	assign s_accept      = s_axis_tvalid && s_axis_tready;
	assign m_accept      = m_axis_tvalid && m_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	assign ctrl.load      = s_accept;
	assign ctrl.div_step  = state_q == S_DIV;
	assign ctrl.mul1_step = (state_q == S_DIV) && (cnt_q < CNT_DT);
	assign ctrl.mul2_load = state_q == S_MLD;
	assign ctrl.mul2_step = state_q == S_MUL;
	assign ctrl.finish    = (state_q == S_FIN) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_zone_q <= stp_pkg::DZ_RESET;
			sens_x_q    <= stp_pkg::SENS_RESET;
			sens_y_q    <= stp_pkg::SENS_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				stp_pkg::REG_DEAD_ZONE: dead_zone_q <= cfg_data[stp_pkg::DZ_W-1:0];
				stp_pkg::REG_SENS_X:    sens_x_q    <= cfg_data;
				stp_pkg::REG_SENS_Y:    sens_y_q    <= cfg_data;
				default: begin
					// drop writes to unmapped indexes
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_accept) begin
						state_q <= S_DIV;
						cnt_q   <= '0;
					end
				end
				S_DIV: begin
					if (cnt_q == CNT_LAST) begin
						state_q <= S_MLD;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_MLD: begin
					state_q <= S_MUL;
					cnt_q   <= '0;
				end
				S_MUL: begin
					if (cnt_q == CNT_LAST) begin
						state_q <= S_FIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_FIN: begin
					// hold until the output register can take the result
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.finish) begin
			out_valid_q <= 1'b1;
		end else if (m_accept) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.finish) begin
			out_data_q <= {delta_y, delta_x};
		end
	end

	stp_axis #(
		.HALF_RANGE(HALF_RANGE)
	) u_axis_x (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.stick      (s_axis_tdata[stp_pkg::STICK_W-1:0]),
		.frame_time (s_axis_tdata[stp_pkg::IN_DATA_W-1:2*stp_pkg::STICK_W]),
		.dead_zone  (dead_zone_q),
		.sensitivity(sens_x_q),
		.delta      (delta_x)
	);

	stp_axis #(
		.HALF_RANGE(HALF_RANGE)
	) u_axis_y (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.stick      (s_axis_tdata[2*stp_pkg::STICK_W-1:stp_pkg::STICK_W]),
		.frame_time (s_axis_tdata[stp_pkg::IN_DATA_W-1:2*stp_pkg::STICK_W]),
		.dead_zone  (dead_zone_q),
		.sensitivity(sens_y_q),
		.delta      (delta_y)
	);

endmodule

// ----- sv/stp_smul.sv -----
// ----------------------------------------------------------------------------
// stp_smul
// Shift-add multiplier: one multiplier bit per step, product shifts right.
// ----------------------------------------------------------------------------
module stp_smul #(
	parameter int MC_W = 24,
	parameter int ML_W = 16
) (
	input  logic                   clk,
	input  logic                   load,
	input  logic                   step,
	input  logic [MC_W-1:0]        mcand,
	input  logic [ML_W-1:0]        mplier,
	output logic [MC_W+ML_W-1:0]   product
);

	logic [MC_W-1:0] mc_q;
	logic [MC_W-1:0] hi_q;
	logic [ML_W-1:0] lo_q;
	logic [MC_W:0]   sum;

	assign sum     = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mc_q} : '0);
	assign product = {hi_q, lo_q};

	always_ff @(posedge clk) begin
		if (load) begin
			mc_q <= mcand;
			hi_q <= '0;
			lo_q <= mplier;
		end else if (step) begin
			hi_q <= sum[MC_W:1];
			lo_q <= {sum[0], lo_q[ML_W-1:1]};
		end
	end

endmodule

// ----- sv/stp_div.sv -----
// ----------------------------------------------------------------------------
// stp_div
// Restoring divider for the push ratio: one quotient bit per step, MSB first.
// ----------------------------------------------------------------------------
module stp_div #(
	parameter int DEN_W = 8
) (
	input  logic                        clk,
	input  logic                        load,
	input  logic                        step,
	input  logic [DEN_W-1:0]            num,
	input  logic [DEN_W-1:0]            den,
	input  logic                        sat,
	output logic [stp_pkg::RATIO_W-1:0] ratio
);

	logic [DEN_W:0]                r_q;
	logic [DEN_W-1:0]              d_q;
	logic [stp_pkg::RATIO_W-1:0]   q_q;
	logic                          sat_q;
	logic [DEN_W:0]                diff;
	logic [DEN_W:0]                rsel;
	logic                          ge;

	assign ge    = r_q >= {1'b0, d_q};
	assign diff  = r_q - {1'b0, d_q};
	assign rsel  = ge ? diff : r_q;
	assign ratio = sat_q ? stp_pkg::RATIO_MAX : q_q;

	always_ff @(posedge clk) begin
		if (load) begin
			r_q   <= {1'b0, num};
			d_q   <= den;
			q_q   <= '0;
			sat_q <= sat;
		end else if (step) begin
			// partial remainder stays below the divisor, so the top bit drops out
			r_q <= {rsel[DEN_W-1:0], 1'b0};
			q_q <= {q_q[stp_pkg::RATIO_W-2:0], ge};
		end
	end

endmodule

// ----- sv/stp_axis.sv -----
// ----------------------------------------------------------------------------
// stp_axis
// One axis: centering, dead zone, serial ratio and rate product, remainder
// accumulation with truncation toward zero and saturation.
// ----------------------------------------------------------------------------
module stp_axis #(
	parameter int HALF_RANGE = 128
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  stp_pkg::stp_ctrl_t             ctrl,
	input  logic [stp_pkg::STICK_W-1:0]    stick,
	input  logic [stp_pkg::DT_W-1:0]       frame_time,
	input  logic [stp_pkg::DZ_W-1:0]       dead_zone,
	input  logic [stp_pkg::SENS_W-1:0]     sensitivity,
	output stp_pkg::delta_t                delta
);

	localparam int MAG_W = $clog2(((HALF_RANGE > 255) ? HALF_RANGE : 255) + 1);
	localparam logic [MAG_W-1:0] HR_V = MAG_W'(HALF_RANGE);

	logic [MAG_W-1:0] raw_ext;
	logic [MAG_W-1:0] dz_ext;
	logic [MAG_W-1:0] mag;
	logic [MAG_W-1:0] den;
	logic [MAG_W-1:0] num;
	logic             neg;
	logic             rest;
	logic             sat;
	logic             neg_q;
	logic             rest_q;

	logic [stp_pkg::RATIO_W-1:0] ratio;
	logic [stp_pkg::P1_W-1:0]    p1;
	logic [stp_pkg::P2_W-1:0]    p2;
	logic [stp_pkg::INCR_W-1:0]  incr;
	logic [stp_pkg::SUM_W-1:0]   incr_ext;
	logic [stp_pkg::SUM_W-1:0]   incr_s;
	logic [stp_pkg::SUM_W-1:0]   rem_ext;
	logic [stp_pkg::SUM_W-1:0]   sum;
	logic [stp_pkg::WHOLE_W-1:0] whole;
	logic                        adj;
	logic                        ovf;
	logic [stp_pkg::REM_W-1:0]   rem_q;
	logic [stp_pkg::REM_W-1:0]   rem_next;

	// centering and dead zone, evaluated on the request cycle
	assign raw_ext = MAG_W'(stick);
	assign dz_ext  = MAG_W'(dead_zone);
	assign neg     = raw_ext < HR_V;
	assign mag     = neg ? (HR_V - raw_ext) : (raw_ext - HR_V);
	assign rest    = mag <= dz_ext;
	assign den     = HR_V - dz_ext;
	assign num     = mag - dz_ext;
	// ratio of two or more, or a divisor at or below zero, pins the ratio
	assign sat     = !(HR_V > dz_ext) || ({1'b0, num} >= {den, 1'b0});

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			neg_q  <= neg;
			rest_q <= rest;
		end
	end

	stp_div #(
		.DEN_W(MAG_W)
	) u_div (
		.clk  (clk),
		.load (ctrl.load),
		.step (ctrl.div_step),
		.num  (num),
		.den  (den),
		.sat  (sat),
		.ratio(ratio)
	);

	// sensitivity times frame time runs alongside the divide
	stp_smul #(
		.MC_W(stp_pkg::SENS_W),
		.ML_W(stp_pkg::DT_W)
	) u_mul_rate (
		.clk    (clk),
		.load   (ctrl.load),
		.step   (ctrl.mul1_step),
		.mcand  (sensitivity),
		.mplier (frame_time),
		.product(p1)
	);

	stp_smul #(
		.MC_W(stp_pkg::P1_W),
		.ML_W(stp_pkg::RATIO_W)
	) u_mul_ratio (
		.clk    (clk),
		.load   (ctrl.mul2_load),
		.step   (ctrl.mul2_step),
		.mcand  (p1),
		.mplier (ratio),
		.product(p2)
	);

	assign incr     = p2[stp_pkg::P2_W-1 -: stp_pkg::INCR_W];
	assign incr_ext = stp_pkg::SUM_W'(incr);
	assign incr_s   = neg_q ? (~incr_ext + 1'b1) : incr_ext;
	assign rem_ext  = {{(stp_pkg::SUM_W-stp_pkg::REM_W){rem_q[stp_pkg::REM_W-1]}}, rem_q};
	assign sum      = rem_ext + incr_s;

	// truncate toward zero: a negative sum with a fraction rounds its whole part up
	assign adj   = sum[stp_pkg::SUM_W-1] & (|sum[stp_pkg::FRAC_W-1:0]);
	assign whole = sum[stp_pkg::SUM_W-1:stp_pkg::FRAC_W] + stp_pkg::WHOLE_W'(adj);
	assign ovf   = !((&whole[stp_pkg::WHOLE_W-1:stp_pkg::DELTA_W-1]) ||
		!(|whole[stp_pkg::WHOLE_W-1:stp_pkg::DELTA_W-1]));

	always_comb begin
		if (rest_q) begin
			delta    = '0;
			rem_next = '0;
		end else begin
			rem_next = {adj, sum[stp_pkg::FRAC_W-1:0]};
			if (ovf) begin
				delta = whole[stp_pkg::WHOLE_W-1] ? stp_pkg::DELTA_MIN : stp_pkg::DELTA_MAX;
			end else begin
				delta = whole[stp_pkg::DELTA_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (ctrl.finish) begin
			rem_q <= rem_next;
		end
	end

endmodule

// ----- sv/stp_checker.sv -----
// ----------------------------------------------------------------------------
// stp_checker
// Port-level checks of the stick to pointer delta unit, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stp_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               s_axis_tvalid,
	input logic                               s_axis_tready,
	input logic                               m_axis_tvalid,
	input logic                               m_axis_tready,
	input logic [stp_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

	// a taken request makes the unit busy and drops the input ready
	`STP_ASSERT_NEXT(a_busy_after_req, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready ##1 !s_axis_tready)

	// a stalled result holds
	`STP_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

	// a new result frees the input side in the same cycle
	`STP_ASSERT_IMPLY(a_result_frees_input, clk, arst_n, $rose(m_axis_tvalid), s_axis_tready)

endmodule

bind stick_to_pointer_delta_unit stp_checker u_stp_checker (.*);
